// ===== design/flat_triangle_normals_macros.svh =====
// Assertion macros shared by the flat_triangle_normals RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FLAT_TRIANGLE_NORMALS_MACROS_SVH
`define FLAT_TRIANGLE_NORMALS_MACROS_SVH

// same-cycle implication
`define FTN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FTN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ftn_pkg.sv =====
// Types and codes for the flat triangle normal block.
// No dependencies; imported by the top level.
`default_nettype none

package ftn_pkg;

   typedef logic [1:0]         mode_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [15:0] coord_type;
   typedef logic [10:0]        count_type;

   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_TRI   = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;
   localparam mode_type MODE_NONE  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_DEGEN = 2'd2;

endpackage

`default_nettype wire

// ===== design/ftn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ftn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/flat_triangle_normals.sv =====
// Top level of the flat triangle normal block: vertex stores, sequencer, shared datapath.
// Depends on ftn_pkg, ftn_ram and flat_triangle_normals_macros.svh.
`default_nettype none
`include "flat_triangle_normals_macros.svh"

// A command transfers when start is high and busy is low; busy stays high
// until the result strobe, so one command is in flight at a time. Each
// command returns exactly one result, shown for one cycle with rsp_valid;
// the receiver cannot stall, so capture it in that cycle. After reset all
// MAX_VERTICES entries of the normal store are swept to zero, one entry a
// cycle, with busy high; csr writes are taken at any time. A triangle
// reads its three positions, forms the cross product on the one 31x31
// multiplier, block-shifts so that the largest component lies in
// [2^29, 2^30), forms the sum of squares, then runs 31 square-root steps
// and three divides that share one 64-bit compare-subtract, and writes the
// normal back to all three vertices.
module flat_triangle_normals #(
   parameter int MAX_VERTICES = 1024,
   parameter int INDEX_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire ftn_pkg::mode_type      req_mode,
   input  wire logic [INDEX_BITS-1:0]  req_index_a,
   input  wire logic [INDEX_BITS-1:0]  req_index_b,
   input  wire logic [INDEX_BITS-1:0]  req_index_c,
   input  wire ftn_pkg::coord_type     req_pos_x,
   input  wire ftn_pkg::coord_type     req_pos_y,
   input  wire ftn_pkg::coord_type     req_pos_z,
   output logic                        rsp_valid,
   output ftn_pkg::status_type         rsp_status,
   output ftn_pkg::coord_type          rsp_normal_x,
   output ftn_pkg::coord_type          rsp_normal_y,
   output ftn_pkg::coord_type          rsp_normal_z,
   input  wire logic                   csr_write_enable,
   input  wire ftn_pkg::count_type     csr_write_data
);

   import ftn_pkg::*;

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   // index compare width: holds any index and the store depth itself
   localparam int CW = (INDEX_BITS > 17) ? INDEX_BITS : 17;
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_VERTICES);
   localparam logic [AW-1:0] LAST_A = AW'(MAX_VERTICES - 1);

   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WPOS  = 4'd2;
   localparam logic [3:0] S_RDN   = 4'd3;
   localparam logic [3:0] S_RDN2  = 4'd4;
   localparam logic [3:0] S_POS   = 4'd5;
   localparam logic [3:0] S_CROSS = 4'd6;
   localparam logic [3:0] S_ABS   = 4'd7;
   localparam logic [3:0] S_SHIFT = 4'd8;
   localparam logic [3:0] S_SQ    = 4'd9;
   localparam logic [3:0] S_ROOT  = 4'd10;
   localparam logic [3:0] S_DSET  = 4'd11;
   localparam logic [3:0] S_DIV   = 4'd12;
   localparam logic [3:0] S_WB    = 4'd13;
   localparam logic [3:0] S_RESP  = 4'd14;

   function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
      return v[AW-1:0];
   endfunction

   function automatic logic signed [16:0] diff17(input logic [15:0] a, input logic [15:0] b);
      return {a[15], a} - {b[15], b};
   endfunction

   function automatic logic signed [30:0] ext17(input logic signed [16:0] v);
      return {{14{v[16]}}, v};
   endfunction

   // control state
   logic [3:0]    state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [1:0]    k_ff, k_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          valid_ff, valid_in;
   count_type     vc_ff, vc_in;

   // command and datapath payload
   logic [CW-1:0]  ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic [47:0]    pos_ff, pos_in;
   status_type     st_ff, st_in;
   coord_type      nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [47:0]    p0_ff, p0_in;
   logic signed [16:0] e1_ff [3];
   logic signed [16:0] e1_in [3];
   logic signed [16:0] e2_ff [3];
   logic signed [16:0] e2_in [3];
   logic signed [61:0] prod_ff, prod_in;
   logic signed [35:0] hold_ff, hold_in;
   logic signed [35:0] c_ff [3];
   logic signed [35:0] c_in [3];
   logic [35:0]    u_ff [3];
   logic [35:0]    u_in [3];
   logic [35:0]    m_ff, m_in;
   logic [62:0]    rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in, dsh_ff, dsh_in;
   logic [15:0]    q_ff, q_in;

   // shared multiplier and compare-subtract
   logic signed [30:0] mul_a, mul_b;
   logic [62:0]    trial;
   logic [63:0]    diff;
   logic           ge;

   // stores
   logic          pw_en, nw_en;
   logic [AW-1:0] pw_addr, pr_addr, nw_addr, nr_addr;
   logic [47:0]   pw_data, pr_data, nw_data, nr_data;

   // command checks
   logic [CW-1:0] lim, ra, rb, rc;
   logic          oob_a, tri_bad;
   logic [35:0]   abs_v [3];
   logic [35:0]   u_sel;
   logic [15:0]   q_fin;
   coord_type     n_fin;

   assign ra = CW'(req_index_a);
   assign rb = CW'(req_index_b);
   assign rc = CW'(req_index_c);
   assign lim = (CW'(vc_ff) > MAX_C) ? MAX_C : CW'(vc_ff);
   assign oob_a = ra >= MAX_C;
   assign tri_bad = (ra >= lim) || (rb >= lim) || (rc >= lim);

   assign trial = (state_ff == S_ROOT) ? (res_ff + bit_ff) : dsh_ff;
   assign diff  = {1'b0, rem_ff} - {1'b0, trial};
   assign ge    = !diff[63];
   assign prod_in = mul_a * mul_b;

   assign q_fin = {q_ff[14:0], ge};
   assign n_fin = c_ff[k_ff][35] ? -coord_type'(q_fin) : coord_type'(q_fin);
   assign u_sel = u_ff[k_ff];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = c_ff[i][35] ? 36'(-c_ff[i]) : 36'(c_ff[i]);
      end
   end

   assign vc_in = csr_write_enable ? csr_write_data : vc_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      clr_in   = clr_ff;
      valid_in = 1'b0;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      ic_in    = ic_ff;
      pos_in   = pos_ff;
      st_in    = st_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nz_in    = nz_ff;
      p0_in    = p0_ff;
      e1_in    = e1_ff;
      e2_in    = e2_ff;
      hold_in  = hold_ff;
      c_in     = c_ff;
      u_in     = u_ff;
      m_in     = m_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      mul_a    = '0;
      mul_b    = '0;
      pw_en    = 1'b0;
      pw_addr  = to_addr(ia_ff);
      pw_data  = pos_ff;
      pr_addr  = to_addr(ia_ff);
      nw_en    = 1'b0;
      nw_addr  = to_addr(ia_ff);
      nw_data  = '0;
      nr_addr  = to_addr(ia_ff);

      case (state_ff)
         S_CLEAR: begin
            nw_en   = 1'b1;
            nw_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               ia_in   = ra;
               ib_in   = rb;
               ic_in   = rc;
               pos_in  = {req_pos_x, req_pos_y, req_pos_z};
               st_in   = ST_OK;
               nx_in   = '0;
               ny_in   = '0;
               nz_in   = '0;
               cnt_in  = '0;
               k_in    = '0;
               case (req_mode)
                  MODE_WRITE: begin
                     if (oob_a) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_WPOS;
                     end
                  end
                  MODE_TRI: begin
                     if (tri_bad) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_POS;
                     end
                  end
                  MODE_READ: begin
                     if (oob_a) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_RDN;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_WPOS: begin
            // new position clears the stored normal
            pw_en    = 1'b1;
            nw_en    = 1'b1;
            state_in = S_RESP;
         end
         S_RDN: state_in = S_RDN2;
         S_RDN2: begin
            nx_in    = nr_data[47:32];
            ny_in    = nr_data[31:16];
            nz_in    = nr_data[15:0];
            state_in = S_RESP;
         end
         S_POS: begin
            // addresses a, b, c; each read returns in the cycle after its address
            case (cnt_ff)
               5'd0:    pr_addr = to_addr(ia_ff);
               5'd1:    pr_addr = to_addr(ib_ff);
               default: pr_addr = to_addr(ic_ff);
            endcase
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd1: p0_in = pr_data;
               5'd2: begin
                  e1_in[0] = diff17(pr_data[47:32], p0_ff[47:32]);
                  e1_in[1] = diff17(pr_data[31:16], p0_ff[31:16]);
                  e1_in[2] = diff17(pr_data[15:0],  p0_ff[15:0]);
               end
               5'd3: begin
                  e2_in[0] = diff17(pr_data[47:32], p0_ff[47:32]);
                  e2_in[1] = diff17(pr_data[31:16], p0_ff[31:16]);
                  e2_in[2] = diff17(pr_data[15:0],  p0_ff[15:0]);
                  cnt_in   = '0;
                  state_in = S_CROSS;
               end
               default: ;
            endcase
         end
         S_CROSS: begin
            case (cnt_ff)
               5'd0: begin mul_a = ext17(e1_ff[1]); mul_b = ext17(e2_ff[2]); end
               5'd1: begin mul_a = ext17(e1_ff[2]); mul_b = ext17(e2_ff[1]); end
               5'd2: begin mul_a = ext17(e1_ff[2]); mul_b = ext17(e2_ff[0]); end
               5'd3: begin mul_a = ext17(e1_ff[0]); mul_b = ext17(e2_ff[2]); end
               5'd4: begin mul_a = ext17(e1_ff[0]); mul_b = ext17(e2_ff[1]); end
               5'd5: begin mul_a = ext17(e1_ff[1]); mul_b = ext17(e2_ff[0]); end
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            // product is registered and lands in the cycle after its operands
            case (cnt_ff)
               5'd1, 5'd3, 5'd5: hold_in = prod_ff[35:0];
               5'd2: c_in[0] = hold_ff - prod_ff[35:0];
               5'd4: c_in[1] = hold_ff - prod_ff[35:0];
               5'd6: begin
                  c_in[2]  = hold_ff - prod_ff[35:0];
                  state_in = S_ABS;
               end
               default: ;
            endcase
         end
         S_ABS: begin
            u_in = abs_v;
            m_in = abs_v[0];
            if (abs_v[1] > m_in) m_in = abs_v[1];
            if (abs_v[2] > m_in) m_in = abs_v[2];
            if (m_in == '0) begin
               st_in    = ST_DEGEN;
               state_in = S_RESP;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (m_ff[35:30] != '0) begin
               for (int i = 0; i < 3; i++) u_in[i] = u_ff[i] >> 1;
               m_in = m_ff >> 1;
            end else if (m_ff[35:29] == '0) begin
               for (int i = 0; i < 3; i++) u_in[i] = u_ff[i] << 1;
               m_in = m_ff << 1;
            end else begin
               cnt_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            case (cnt_ff)
               5'd0: begin mul_a = {1'b0, u_ff[0][29:0]}; mul_b = mul_a; end
               5'd1: begin mul_a = {1'b0, u_ff[1][29:0]}; mul_b = mul_a; end
               5'd2: begin mul_a = {1'b0, u_ff[2][29:0]}; mul_b = mul_a; end
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd1: rem_in = {1'b0, prod_ff};
               5'd2: rem_in = rem_ff + {1'b0, prod_ff};
               5'd3: begin
                  rem_in   = rem_ff + {1'b0, prod_ff};
                  res_in   = '0;
                  bit_in   = 63'(1) << 60;
                  cnt_in   = 5'd30;
                  state_in = S_ROOT;
               end
               default: ;
            endcase
         end
         S_ROOT: begin
            if (ge) begin
               rem_in = diff[62:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DSET;
            end
         end
         S_DSET: begin
            // (u << 15 + r) / (2r), quotient bits 15 down to 0
            rem_in   = (63'(u_sel) << 15) + res_ff;
            dsh_in   = res_ff << 16;
            q_in     = '0;
            cnt_in   = 5'd15;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (ge) begin
               rem_in = diff[62:0];
            end
            q_in   = q_fin;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               case (k_ff)
                  2'd0:    nx_in = n_fin;
                  2'd1:    ny_in = n_fin;
                  default: nz_in = n_fin;
               endcase
               k_in = k_ff + 1'b1;
               if (k_ff == 2'd2) begin
                  cnt_in   = '0;
                  state_in = S_WB;
               end else begin
                  state_in = S_DSET;
               end
            end
         end
         S_WB: begin
            nw_en   = 1'b1;
            nw_data = {nx_ff, ny_ff, nz_ff};
            case (cnt_ff)
               5'd0:    nw_addr = to_addr(ia_ff);
               5'd1:    nw_addr = to_addr(ib_ff);
               default: nw_addr = to_addr(ic_ff);
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd2) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         k_ff     <= '0;
         clr_ff   <= '0;
         valid_ff <= 1'b0;
         vc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         clr_ff   <= clr_in;
         valid_ff <= valid_in;
         vc_ff    <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff   <= ia_in;
      ib_ff   <= ib_in;
      ic_ff   <= ic_in;
      pos_ff  <= pos_in;
      st_ff   <= st_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nz_ff   <= nz_in;
      p0_ff   <= p0_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      c_ff    <= c_in;
      u_ff    <= u_in;
      m_ff    <= m_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

   ftn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock (clock),
      .we    (pw_en),
      .waddr (pw_addr),
      .wdata (pw_data),
      .raddr (pr_addr),
      .rdata (pr_data)
   );

   ftn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_nrm_ram (
      .clock (clock),
      .we    (nw_en),
      .waddr (nw_addr),
      .wdata (nw_data),
      .raddr (nr_addr),
      .rdata (nr_data)
   );

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_status   = st_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;
   assign rsp_normal_z = nz_ff;

   `FTN_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `FTN_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "not busy after transfer")
   `FTN_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `FTN_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0), "nonzero normal on failed command")
   `FTN_ASSERT_NOW(a_div_comp, clock, reset, state_ff == S_DIV, k_ff != 2'd3, "divide past last component")

endmodule

`default_nettype wire
